>>> hdl/cas_pkg.sv
`default_nettype none

package cas_pkg;

  // Which side holds authority over the vehicle.
  typedef enum logic [1:0] {
    OWN_INITIAL = 2'd0,
    OWN_NONE    = 2'd1,
    OWN_REMOTE  = 2'd2,
    OWN_PILOT   = 2'd3
  } owner_t;

  // Item kinds carried on the mode field.
  localparam logic [1:0] MODE_REMOTE = 2'd0;
  localparam logic [1:0] MODE_PILOT  = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam int unsigned WD_W = 16;
  localparam logic [WD_W-1:0] WATCHDOG_RESET = 16'd500;

  typedef struct packed {
    owner_t owner;
    logic   shutdown;
    logic   remote_alive;
    logic   pilot_alive;
    logic   throttle;
    logic   allowed;
    logic   request;
  } sup_state_t;

  typedef struct packed {
    sup_state_t st;
    logic       ev_shutdown;
    logic       ev_changed;
  } sup_decide_t;

  // One evaluation of the authority decision on the given state.
  function automatic sup_decide_t cas_decide(sup_state_t s);
    sup_decide_t r;
    owner_t      want;
    r             = '0;
    r.st          = s;
    if (s.remote_alive && s.pilot_alive) begin
      if (s.request && s.allowed && !s.shutdown) begin
        want = OWN_PILOT;
      end else begin
        want = OWN_REMOTE;
      end
    end else if (s.remote_alive) begin
      want = OWN_REMOTE;
    end else begin
      want = OWN_NONE;
    end
    // The initial owner is held until some source shows up.
    if (!(s.owner == OWN_INITIAL && want == OWN_NONE) && s.owner != want) begin
      if (want != OWN_PILOT) begin
        r.ev_shutdown = !s.shutdown;
        r.st.shutdown = 1'b1;
      end
      r.st.owner   = want;
      r.ev_changed = 1'b1;
    end
    // The remote clears a shutdown by holding its throttle low.
    if (r.st.owner == OWN_REMOTE && r.st.shutdown && !r.st.throttle) begin
      r.st.shutdown = 1'b0;
      r.ev_changed  = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/control_authority_supervisor.sv
// An item accepted into the input register moves on into the result register, which drives the out_ ports.
// Throughput: one item per cycle; the input register refills in the same cycle that the
// result register takes its item, so only a held out_stall slows the flow.
// Reset (rst_n, synchronous, active low): owner initial, shutdown in force, both sources
// lost, watchdog countdowns zero, watchdog reload value back to 500, both registers empty.
`default_nettype none

module control_authority_supervisor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration: watchdog reload value.
  input  wire logic       cfg_we,
  input  wire logic [15:0] cfg_data,
  // Input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_mode,
  input  wire logic       in_throttle_high,
  input  wire logic       in_pilot_allowed,
  input  wire logic       in_want_control,
  // Result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_in_control,
  output logic            out_shutdown_active,
  output logic            out_shutdown_event,
  output logic            out_changed_event
);

  // Watchdog reload value; the user must write it only while the block is idle (not enforced).
  logic [cas_pkg::WD_W-1:0] wd_r;

  // Input register. It holds one transferred item until the result register can take it.
  logic       in_valid_r;
  logic [1:0] mode_r;
  logic       throttle_r;
  logic       allowed_in_r;
  logic       want_r;

  // Supervisor state. It is updated in the same edge that loads the result register, so
  // an item that follows in the next cycle sees the state left by this one.
  cas_pkg::sup_state_t      state_r;
  logic [cas_pkg::WD_W-1:0] rc_r;
  logic [cas_pkg::WD_W-1:0] pc_r;

  // Result register.
  logic       out_valid_r;
  logic [1:0] owner_out_r;
  logic       shutdown_out_r;
  logic       ev_shutdown_r;
  logic       ev_changed_r;

  // Next values from the combinational step.
  cas_pkg::sup_state_t      state_nxt;
  logic [cas_pkg::WD_W-1:0] rc_nxt;
  logic [cas_pkg::WD_W-1:0] pc_nxt;
  logic                     ev_shutdown_nxt;
  logic                     ev_changed_nxt;

  cas_pkg::sup_decide_t dec_a;
  cas_pkg::sup_decide_t dec_b;
  cas_pkg::sup_state_t  st_tmp;

  logic out_free;
  logic step_fire;

  // The result register can take a new item when it is empty or its result is being
  // transferred out in this cycle. The input register refills when empty or under that condition.
  assign out_free  = !out_valid_r || !out_stall;
  assign step_fire = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;

  always_comb begin
    st_tmp          = state_r;
    rc_nxt          = rc_r;
    pc_nxt          = pc_r;
    dec_a           = '0;
    dec_b           = '0;
    state_nxt       = state_r;
    ev_shutdown_nxt = 1'b0;
    ev_changed_nxt  = 1'b0;
    case (mode_r)
      cas_pkg::MODE_REMOTE: begin
        // A remote report latches its switches and restarts the remote watchdog.
        st_tmp.throttle     = throttle_r;
        st_tmp.allowed      = allowed_in_r;
        st_tmp.remote_alive = 1'b1;
        rc_nxt              = wd_r;
        dec_a               = cas_pkg::cas_decide(st_tmp);
        state_nxt           = dec_a.st;
        ev_shutdown_nxt     = dec_a.ev_shutdown;
        ev_changed_nxt      = dec_a.ev_changed || (state_r.allowed != allowed_in_r);
      end
      cas_pkg::MODE_PILOT: begin
        st_tmp.request     = want_r;
        st_tmp.pilot_alive = 1'b1;
        pc_nxt             = wd_r;
        dec_a              = cas_pkg::cas_decide(st_tmp);
        state_nxt          = dec_a.st;
        ev_shutdown_nxt    = dec_a.ev_shutdown;
        ev_changed_nxt     = dec_a.ev_changed;
      end
      cas_pkg::MODE_TICK: begin
        // Both watchdogs count down and stop at zero. The remote lost check and its
        // decision come first, then the pilot lost check and its decision.
        rc_nxt = rc_r - cas_pkg::WD_W'(rc_r != '0);
        pc_nxt = pc_r - cas_pkg::WD_W'(pc_r != '0);
        if (rc_nxt == '0) begin
          st_tmp.remote_alive = 1'b0;
          dec_a               = cas_pkg::cas_decide(st_tmp);
          st_tmp              = dec_a.st;
        end
        if (pc_nxt == '0) begin
          st_tmp.pilot_alive = 1'b0;
          dec_b              = cas_pkg::cas_decide(st_tmp);
          st_tmp             = dec_b.st;
        end
        state_nxt       = st_tmp;
        ev_shutdown_nxt = dec_a.ev_shutdown || dec_b.ev_shutdown;
        ev_changed_nxt  = dec_a.ev_changed || dec_b.ev_changed;
      end
      default: begin
        // The unused code leaves the state alone and reports no events.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r <= cas_pkg::WATCHDOG_RESET;
    end else if (cfg_we) begin
      wd_r <= cfg_data;
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || out_free) begin
      in_valid_r <= in_valid;
    end
  end

  // Input payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r       <= in_mode;
      throttle_r   <= in_throttle_high;
      allowed_in_r <= in_pilot_allowed;
      want_r       <= in_want_control;
    end
  end

  // Supervisor state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.owner        <= cas_pkg::OWN_INITIAL;
      state_r.shutdown     <= 1'b1;
      state_r.remote_alive <= 1'b0;
      state_r.pilot_alive  <= 1'b0;
      state_r.throttle     <= 1'b0;
      state_r.allowed      <= 1'b0;
      state_r.request      <= 1'b0;
      rc_r                 <= '0;
      pc_r                 <= '0;
    end else if (step_fire) begin
      state_r <= state_nxt;
      rc_r    <= rc_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (step_fire) begin
      owner_out_r    <= state_nxt.owner;
      shutdown_out_r <= state_nxt.shutdown;
      ev_shutdown_r  <= ev_shutdown_nxt;
      ev_changed_r   <= ev_changed_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_in_control      = owner_out_r;
  assign out_shutdown_active = shutdown_out_r;
  assign out_shutdown_event  = ev_shutdown_r;
  assign out_changed_event   = ev_changed_r;

`ifndef NO_ASSERTIONS
  // The pilot never holds control while a throttle shutdown is in force.
  a_pilot_no_shutdown: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.owner == cas_pkg::OWN_PILOT |-> !state_r.shutdown)
    else $error("pilot owns control during shutdown");

  // The pilot holds control only while both sources are alive.
  a_pilot_sources_alive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.owner == cas_pkg::OWN_PILOT |-> state_r.remote_alive && state_r.pilot_alive)
    else $error("pilot owns control with a source lost");

  // Once the initial owner is left, it is never reentered.
  a_no_return_initial: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.owner != cas_pkg::OWN_INITIAL |=> state_r.owner != cas_pkg::OWN_INITIAL)
    else $error("owner returned to initial");

  // A shutdown is only ever issued by an owner change, so a result that reports one
  // also reports a change.
  a_event_implies_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_shutdown_r |-> ev_changed_r)
    else $error("shutdown event without change event");

  // The state moves only when an item passes into the result register.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_fire |=> $stable(state_r) && $stable(rc_r) && $stable(pc_r))
    else $error("state changed without a step");
`endif

endmodule

`default_nettype wire
